// File: rtl/qtst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtst_pkg
// Shared types and constants of the quintic time-scaling trajectory unit.
// ----------------------------------------------------------------------------
package qtst_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FRAC_W   = 28;            // fraction bits of s
  localparam int unsigned S_W      = FRAC_W + 1;    // s in [0, 1.0]
  localparam int unsigned COMB_W   = 37;            // signed blend terms
  localparam int unsigned MAG_W    = COMB_W - 1;
  localparam int unsigned DLT_W    = WORD_W + 1;    // goal - start
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned QS_W     = WORD_W - 1;    // unsaturated quotient bits
  localparam int unsigned Q1_W     = 59;            // first accel quotient
  localparam int unsigned VSH      = 12;            // velocity divisor shift
  localparam int unsigned ASH      = 4;             // accel scale 16
  localparam int unsigned VOVF_SH  = VSH + QS_W;    // 43
  localparam int unsigned AOVF_SH  = QS_W - ASH;    // 27

  localparam logic [WORD_W-1:0] DURATION_RST = 32'h0001_0000;

  // blend coefficients
  localparam int C_H3 = 10;
  localparam int C_H4 = 15;
  localparam int C_H5 = 6;
  localparam int C_V2 = 30;
  localparam int C_V3 = 60;
  localparam int C_V4 = 30;
  localparam int C_A1 = 60;
  localparam int C_A2 = 180;
  localparam int C_A3 = 120;

  typedef struct packed {
    logic        [WORD_W-1:0] elapsed_time;
    logic signed [WORD_W-1:0] start_angle;
    logic signed [WORD_W-1:0] goal_angle;
  } qtst_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] position;
    logic signed [WORD_W-1:0] velocity;
    logic signed [WORD_W-1:0] acceleration;
    logic                     duration_error;
  } qtst_out_t;

  // carried alongside the time division
  typedef struct packed {
    logic signed [WORD_W-1:0] start;
    logic signed [WORD_W-1:0] goal;
    logic                     err;
  } qtst_ang_t;

  // carried alongside the velocity division
  typedef struct packed {
    logic                     err;
    logic signed [WORD_W-1:0] pos;
    logic                     ovf_v;
    logic                     neg_v;
    logic                     ovf_a;
    logic                     neg_a;
    logic [PROD_W-1:0]        m_a;
  } qtst_vside_t;

  // carried alongside the acceleration divisions
  typedef struct packed {
    logic                     err;
    logic signed [WORD_W-1:0] pos;
    logic                     ovf_v;
    logic                     neg_v;
    logic [QS_W-1:0]          vel_q;
    logic                     ovf_a;
    logic                     neg_a;
  } qtst_aside_t;

endpackage

// File: rtl/quintic_time_scaling_trajectory_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quintic_time_scaling_trajectory_unit
// Quintic blend of one joint: position, velocity and acceleration, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Write the duration (unsigned Q16.16 seconds) on the cfg channel while no
//   word is in flight; cfg_ready_o is always high. Reset loads 1.0 s.
//   Issue a word by raising start with item_i; busy stays low, so a new word
//   may be issued every clock.
//   Each result appears on res_o for one cycle with done_o high, in issue
//   order, after its word passes the input register, the bit-per-stage
//   dividers (29 stages for s = t/duration, 31 for velocity, 59 plus 31 for
//   acceleration), the power and product stages and the output register.
//   Throughput is one word per cycle. The receiver cannot stall; results
//   are not held. Reset empties the pipeline and drops words in flight.
//   A zero duration gives duration_error with zero motion outputs.
// ----------------------------------------------------------------------------
module quintic_time_scaling_trajectory_unit
  import qtst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  qtst_in_t          item_i,
  output logic              done_o,
  output qtst_out_t         res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [WORD_W-1:0] cfg_data_i
);

  // ---- configuration ----
  logic [WORD_W-1:0] duration_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q <= DURATION_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      duration_q <= cfg_data_i;
    end
  end

  // ---- input stage: clamp time ----
  logic              iv_q;
  logic [WORD_W-1:0] it_q;
  qtst_ang_t         ia_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else begin
      iv_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q     <= (item_i.elapsed_time > duration_q) ? duration_q : item_i.elapsed_time;
    ia_q.start <= item_i.start_angle;
    ia_q.goal  <= item_i.goal_angle;
    ia_q.err   <= (duration_q == '0);
  end

  // ---- s = t * 2^28 / duration ----
  logic      sv;
  logic [S_W-1:0] s1;
  qtst_ang_t sa;

  qtst_pipe_div #(
    .NUM_W (WORD_W + FRAC_W),
    .DEN_W (WORD_W),
    .QUO_W (S_W),
    .SIDE_W($bits(qtst_ang_t))
  ) u_div_s (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(iv_q),
    .num_i  ({it_q, FRAC_W'(0)}),
    .den_i  (duration_q),
    .side_i (ia_q),
    .valid_o(sv),
    .quo_o  (s1),
    .side_o (sa)
  );

  // ---- blend polynomials and products ----
  logic              pv;
  logic [PROD_W-1:0] m_v;
  qtst_vside_t       ps;

  qtst_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dur_i  (duration_q),
    .valid_i(sv),
    .s1_i   (s1),
    .ang_i  (sa),
    .valid_o(pv),
    .m_v_o  (m_v),
    .side_o (ps)
  );

  // ---- velocity: m / (duration * 2^12) ----
  logic            vv;
  logic [QS_W-1:0] vq;
  qtst_vside_t     vs;

  qtst_pipe_div #(
    .NUM_W (PROD_W),
    .DEN_W (WORD_W + VSH),
    .QUO_W (QS_W),
    .SIDE_W($bits(qtst_vside_t))
  ) u_div_v (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(pv),
    .num_i  (m_v),
    .den_i  ({duration_q, VSH'(0)}),
    .side_i (ps),
    .valid_o(vv),
    .quo_o  (vq),
    .side_o (vs)
  );

  // ---- acceleration: floor(16 * floor(m / d) / d) ----
  qtst_aside_t a1_in, a1s, a2s;
  logic            a1v, a2v;
  logic [Q1_W-1:0] q1;
  logic [QS_W-1:0] aq;

  always_comb begin
    a1_in.err   = vs.err;
    a1_in.pos   = vs.pos;
    a1_in.ovf_v = vs.ovf_v;
    a1_in.neg_v = vs.neg_v;
    a1_in.vel_q = vq;
    a1_in.ovf_a = vs.ovf_a;
    a1_in.neg_a = vs.neg_a;
  end

  qtst_pipe_div #(
    .NUM_W (PROD_W),
    .DEN_W (WORD_W),
    .QUO_W (Q1_W),
    .SIDE_W($bits(qtst_aside_t))
  ) u_div_a1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(vv),
    .num_i  (vs.m_a),
    .den_i  (duration_q),
    .side_i (a1_in),
    .valid_o(a1v),
    .quo_o  (q1),
    .side_o (a1s)
  );

  qtst_pipe_div #(
    .NUM_W (Q1_W + ASH),
    .DEN_W (WORD_W),
    .QUO_W (QS_W),
    .SIDE_W($bits(qtst_aside_t))
  ) u_div_a2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(a1v),
    .num_i  ({q1, ASH'(0)}),
    .den_i  (duration_q),
    .side_i (a1s),
    .valid_o(a2v),
    .quo_o  (aq),
    .side_o (a2s)
  );

  // ---- output stage: sign, saturate, flag ----
  localparam logic signed [WORD_W-1:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] SMIN = 32'sh8000_0000;

  logic signed [WORD_W-1:0] vel, acc;
  logic                     done_q;
  qtst_out_t                res_q;

  always_comb begin
    if (a2s.ovf_v) begin
      vel = a2s.neg_v ? SMIN : SMAX;
    end else begin
      vel = a2s.neg_v ? -$signed({1'b0, a2s.vel_q}) : $signed({1'b0, a2s.vel_q});
    end
    if (a2s.ovf_a) begin
      acc = a2s.neg_a ? SMIN : SMAX;
    end else begin
      acc = a2s.neg_a ? -$signed({1'b0, aq}) : $signed({1'b0, aq});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= a2v;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.position       <= a2s.err ? '0 : a2s.pos;
    res_q.velocity       <= a2s.err ? '0 : vel;
    res_q.acceleration   <= a2s.err ? '0 : acc;
    res_q.duration_error <= a2s.err;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: rtl/qtst_pipe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtst_pipe_div
// Pipelined restoring divider: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module qtst_pipe_div #(
  parameter int unsigned NUM_W  = 64,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned QUO_W  = 31,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned CMP_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

  logic              vld_q  [QUO_W];
  logic [NUM_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    localparam int unsigned SH = QUO_W - 1 - g;
    logic              v_in;
    logic [NUM_W-1:0]  r_in;
    logic [QUO_W-1:0]  q_in;
    logic [SIDE_W-1:0] s_in;
    logic [CMP_W-1:0]  diff;
    logic              take;

    if (g == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = num_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = vld_q[g-1];
      assign r_in = rem_q[g-1];
      assign q_in = quo_q[g-1];
      assign s_in = side_q[g-1];
    end

    // trial subtract of the shifted divisor
    assign diff = CMP_W'(r_in) - (CMP_W'(den_i) << SH);
    assign take = ~diff[CMP_W-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= v_in;
      end
    end

    // advance remainder, quotient and side word
    always_ff @(posedge clk_i) begin
      rem_q[g]  <= take ? diff[NUM_W-1:0] : r_in;
      quo_q[g]  <= (q_in << 1) | QUO_W'(take);
      side_q[g] <= s_in;
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

// File: rtl/qtst_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtst_poly
// Powers of s, blend terms, products with delta, position and overflow flags.
// ----------------------------------------------------------------------------
module qtst_poly
  import qtst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WORD_W-1:0] dur_i,
  input  logic              valid_i,
  input  logic [S_W-1:0]    s1_i,
  input  qtst_ang_t         ang_i,
  output logic              valid_o,
  output logic [PROD_W-1:0] m_v_o,
  output qtst_vside_t       side_o
);

  localparam int unsigned NPOW = 5;

  // squared duration, refreshed every cycle from the register
  logic [2*WORD_W-1:0] dsq_q;
  always_ff @(posedge clk_i) begin
    dsq_q <= (2*WORD_W)'(dur_i) * (2*WORD_W)'(dur_i);
  end

  // ---- powers: one multiplier per stage ----
  logic                        pv_q  [NPOW-1];
  logic [NPOW-1:0][S_W-1:0]    pw_q  [NPOW-1];
  qtst_ang_t                   pa_q  [NPOW-1];

  for (genvar k = 0; k < NPOW - 1; k++) begin : g_pow
    logic                     v_in;
    logic [NPOW-1:0][S_W-1:0] p_in;
    logic [NPOW-1:0][S_W-1:0] p_d;
    qtst_ang_t                a_in;
    logic [2*S_W-1:0]         prod;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign p_in = {{(NPOW-1)*S_W{1'b0}}, s1_i};
      assign a_in = ang_i;
    end else begin : g_next
      assign v_in = pv_q[k-1];
      assign p_in = pw_q[k-1];
      assign a_in = pa_q[k-1];
    end

    assign prod = p_in[k] * p_in[0];
    always_comb begin
      p_d      = p_in;
      p_d[k+1] = prod[FRAC_W +: S_W];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pv_q[k] <= 1'b0;
      end else begin
        pv_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      pw_q[k] <= p_d;
      pa_q[k] <= a_in;
    end
  end

  // ---- blend terms and magnitudes ----
  logic [NPOW-1:0][S_W-1:0] pw;
  logic signed [COMB_W-1:0] e1, e2, e3, e4, e5, h, dh, d2;
  logic signed [DLT_W-1:0]  delta;
  qtst_ang_t                a4;

  assign pw    = pw_q[NPOW-2];
  assign a4    = pa_q[NPOW-2];
  assign e1    = $signed(COMB_W'(pw[0]));
  assign e2    = $signed(COMB_W'(pw[1]));
  assign e3    = $signed(COMB_W'(pw[2]));
  assign e4    = $signed(COMB_W'(pw[3]));
  assign e5    = $signed(COMB_W'(pw[4]));
  assign h     = COMB_W'(e3 * C_H3 - e4 * C_H4 + e5 * C_H5);
  assign dh    = COMB_W'(e2 * C_V2 - e3 * C_V3 + e4 * C_V4);
  assign d2    = COMB_W'(e1 * C_A1 - e2 * C_A2 + e3 * C_A3);
  assign delta = DLT_W'(a4.goal) - DLT_W'(a4.start);

  logic                     cv_q;
  logic [MAG_W-1:0]         mh_q, mv_q, ma_q;
  logic                     nh_q, nv_q, na_q;
  logic [DLT_W-1:0]         md_q;
  logic signed [WORD_W-1:0] cs_q;
  logic                     ce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= 1'b0;
    end else begin
      cv_q <= pv_q[NPOW-2];
    end
  end

  always_ff @(posedge clk_i) begin
    mh_q <= h[COMB_W-1]  ? MAG_W'(-h)  : MAG_W'(h);
    mv_q <= dh[COMB_W-1] ? MAG_W'(-dh) : MAG_W'(dh);
    ma_q <= d2[COMB_W-1] ? MAG_W'(-d2) : MAG_W'(d2);
    nh_q <= h[COMB_W-1]  ^ delta[DLT_W-1];
    nv_q <= dh[COMB_W-1] ^ delta[DLT_W-1];
    na_q <= d2[COMB_W-1] ^ delta[DLT_W-1];
    md_q <= delta[DLT_W-1] ? DLT_W'(-delta) : DLT_W'(delta);
    cs_q <= a4.start;
    ce_q <= a4.err;
  end

  // ---- products with |delta| ----
  localparam int unsigned MUL_W = MAG_W + DLT_W;

  logic                     xv_q;
  logic [PROD_W-1:0]        xh_q, xv_m_q, xa_q;
  logic                     xnh_q, xnv_q, xna_q;
  logic signed [WORD_W-1:0] xs_q;
  logic                     xe_q;
  logic [MUL_W-1:0]         ph, pv, pa;

  assign ph = MUL_W'(mh_q) * MUL_W'(md_q);
  assign pv = MUL_W'(mv_q) * MUL_W'(md_q);
  assign pa = MUL_W'(ma_q) * MUL_W'(md_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xv_q <= 1'b0;
    end else begin
      xv_q <= cv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xh_q   <= ph[PROD_W-1:0];
    xv_m_q <= pv[PROD_W-1:0];
    xa_q   <= pa[PROD_W-1:0];
    xnh_q  <= nh_q;
    xnv_q  <= nv_q;
    xna_q  <= na_q;
    xs_q   <= cs_q;
    xe_q   <= ce_q;
  end

  // ---- position and overflow checks ----
  localparam int unsigned QH_W  = PROD_W - FRAC_W;
  localparam int unsigned CAP_W = WORD_W + 1;
  localparam int unsigned SUM_W = WORD_W + 3;
  localparam int unsigned AC_W  = 2*WORD_W + AOVF_SH;

  logic [QH_W-1:0]         qh;
  logic [CAP_W-1:0]        qc;
  logic signed [SUM_W-1:0] pofs, psum;
  logic signed [WORD_W-1:0] pos;
  logic                    ovf_v, ovf_a;

  assign qh   = xh_q[PROD_W-1:FRAC_W];
  assign qc   = (qh > QH_W'(CAP_W'(1) << WORD_W)) ? (CAP_W'(1) << WORD_W) : CAP_W'(qh);
  assign pofs = xnh_q ? -$signed(SUM_W'(qc)) : $signed(SUM_W'(qc));
  assign psum = SUM_W'(xs_q) + pofs;

  always_comb begin
    if (psum > SUM_W'(32'sh7FFF_FFFF)) begin
      pos = 32'sh7FFF_FFFF;
    end else if (psum < -SUM_W'(33'sh0_8000_0000)) begin
      pos = 32'sh8000_0000;
    end else begin
      pos = psum[WORD_W-1:0];
    end
  end

  assign ovf_v = WORD_W'(xv_m_q[PROD_W-1:VOVF_SH]) >= dur_i;
  assign ovf_a = AC_W'(xa_q) >= (AC_W'(dsq_q) << AOVF_SH);

  logic        ov_q;
  logic [PROD_W-1:0] om_q;
  qtst_vside_t os_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= xv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    om_q       <= xv_m_q;
    os_q.err   <= xe_q;
    os_q.pos   <= pos;
    os_q.ovf_v <= ovf_v;
    os_q.neg_v <= xnv_q;
    os_q.ovf_a <= ovf_a;
    os_q.neg_a <= xna_q;
    os_q.m_a   <= xa_q;
  end

  assign valid_o = ov_q;
  assign m_v_o   = om_q;
  assign side_o  = os_q;

endmodule

// File: tb/quintic_time_scaling_trajectory_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quintic_time_scaling_trajectory_unit_tb
// Self-checking bench for the quintic blend unit: directed corner words and
// random words over several durations, each result compared as a whole
// against a bit-exact blend predictor, with bursty issue and drain pauses.
// ----------------------------------------------------------------------------
module quintic_time_scaling_trajectory_unit_tb;
  import qtst_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned RANDOM_WORDS   = 1400;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  qtst_in_t          item_i;
  logic              done_o;
  qtst_out_t         res_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [WORD_W-1:0] cfg_data_i;

  logic [WORD_W-1:0] duration_q;
  qtst_out_t         expected_motion[$];
  int unsigned       mismatch_cnt;
  int unsigned       word_cnt;
  int unsigned       result_cnt;
  int unsigned       idle_cycles;
  int unsigned       burst_left;
  bit                watchdog_hit;

  quintic_time_scaling_trajectory_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned mag64(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic longint apply_sign(longint unsigned m, bit neg);
    if (m > 64'h1_0000_0000) m = 64'h1_0000_0000;
    return clip32(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic qtst_out_t blend_predict(qtst_in_t w, logic [WORD_W-1:0] dur);
    longint unsigned t, d, s1, s2, s3, s4, s5, md, m, q, q1, hi;
    longint          h, dhds, d2h, st, gl, delta, pos;
    bit              dneg;
    qtst_out_t       r;
    r = '0;
    d = dur;
    if (d == 0) begin
      r.duration_error = 1'b1;
      return r;
    end
    t = w.elapsed_time;
    if (t > d) t = d;
    st = longint'(w.start_angle);
    gl = longint'(w.goal_angle);
    s1 = (t << FRAC_W) / d;
    s2 = (s1 * s1) >> FRAC_W;
    s3 = (s2 * s1) >> FRAC_W;
    s4 = (s3 * s1) >> FRAC_W;
    s5 = (s4 * s1) >> FRAC_W;
    h    = 10 * longint'(s3) - 15 * longint'(s4) + 6 * longint'(s5);
    dhds = 30 * longint'(s2) - 60 * longint'(s3) + 30 * longint'(s4);
    d2h  = 60 * longint'(s1) - 180 * longint'(s2) + 120 * longint'(s3);
    delta = gl - st;
    md    = mag64(delta);
    dneg  = delta < 0;
    // position
    q = (mag64(h) * md) >> FRAC_W;
    if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    pos = (((h < 0) != dneg) ? -longint'(q) : longint'(q));
    pos = clip32(st + pos);
    r.position = pos[31:0];
    // velocity
    q = (mag64(dhds) * md) / (d << VSH);
    r.velocity = 32'(apply_sign(q, (dhds < 0) != dneg));
    // acceleration via two floor divisions
    m  = mag64(d2h) * md;
    q1 = m / d;
    hi = q1 / d;
    if (hi >= (64'd1 << 28)) q = 64'h1_0000_0000;
    else q = hi * 16 + ((q1 % d) * 16) / d;
    r.acceleration = 32'(apply_sign(q, (d2h < 0) != dneg));
    return r;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      result_cnt <= result_cnt + 1;
      if (expected_motion.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10) $display("unexpected result %h", res_o);
      end else begin
        if (res_o !== expected_motion[0]) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp pos %h vel %h acc %h err %b / got pos %h vel %h acc %h err %b",
                     expected_motion[0].position, expected_motion[0].velocity,
                     expected_motion[0].acceleration, expected_motion[0].duration_error,
                     res_o.position, res_o.velocity, res_o.acceleration,
                     res_o.duration_error);
        end
        void'(expected_motion.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      watchdog_hit = 1'b1;
      $display("watchdog expired");
      $display("quintic_time_scaling_trajectory_unit_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  // Issue one word; bursts of random length, random gaps between them.
  task automatic send_word(qtst_in_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    start  <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy);
    expected_motion.push_back(blend_predict(w, duration_q));
    word_cnt   = word_cnt + 1;
    burst_left = burst_left - 1;
  endtask

  // Hold issue until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (expected_motion.size() != 0) @(posedge clk_i);
    repeat (170) @(posedge clk_i);
  endtask

  task automatic write_duration(logic [WORD_W-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    duration_q = v;
  endtask

  function automatic qtst_in_t make_word(logic [31:0] t, logic [31:0] s, logic [31:0] g);
    qtst_in_t w;
    w.elapsed_time = t;
    w.start_angle  = s;
    w.goal_angle   = g;
    return w;
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_time(logic [31:0] d);
    longint unsigned x;
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return d;
      2: return $urandom;
      3: begin
        x = longint'(d) + $urandom_range(1, 1000);
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
      end
      default: begin
        x = longint'($urandom) % (longint'(d) + 1);
        return x[31:0];
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_reset_duration();
    send_word(make_word(32'h0, 32'h0, 32'h0001_0000));
    send_word(make_word(32'h0000_8000, 32'h0, 32'h0001_0000));
    send_word(make_word(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000));
    send_word(make_word(32'h0000_4000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(make_word(32'h0000_C000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_word(make_word(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(make_word(32'h0002_0000, 32'h1234_5678, 32'h1234_5678));
    send_word(make_word(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000));
  endtask

  task automatic test_zero_duration();
    write_duration(32'h0);
    send_word(make_word(32'h0, 32'h0, 32'h0001_0000));
    send_word(make_word(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(make_word(32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000));
  endtask

  task automatic test_extreme_durations();
    write_duration(32'h0000_0001);
    send_word(make_word(32'h0, 32'h0, 32'h0001_0000));
    send_word(make_word(32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(make_word(32'h0000_0005, 32'h7FFF_FFFF, 32'h8000_0000));
    write_duration(32'hFFFF_FFFF);
    send_word(make_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(make_word(32'hFFFF_FFFF, 32'h0, 32'h0001_0000));
    send_word(make_word(32'h4000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
  endtask

  task automatic test_random_phase(logic [WORD_W-1:0] d, int unsigned n);
    write_duration(d);
    for (int unsigned i = 0; i < n; i++) begin
      send_word(make_word(rand_time(d), rand_angle(), rand_angle()));
      // pause once mid-phase until the pipeline is empty
      if (i == n / 2) drain();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    duration_q   = DURATION_RST;
    mismatch_cnt = 0;
    word_cnt     = 0;
    result_cnt   = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    watchdog_hit = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_duration();
    test_zero_duration();
    test_extreme_durations();
    test_random_phase(32'h0001_0000, RANDOM_WORDS / 7);
    test_random_phase(32'h0000_0001, RANDOM_WORDS / 7);
    test_random_phase(32'hFFFF_FFFF, RANDOM_WORDS / 7);
    test_random_phase($urandom_range(32'h0000_4000, 32'h0008_0000), RANDOM_WORDS / 7);
    test_random_phase($urandom_range(1, 32'h0000_0100), RANDOM_WORDS / 7);
    test_random_phase($urandom, RANDOM_WORDS / 7);
    test_random_phase(32'h0000_8000, RANDOM_WORDS / 7);

    start <= 1'b0;
    while (expected_motion.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d words, %0d results: zero, tiny, huge and random durations,",
             word_cnt, result_cnt);
    $display("clamped and extreme times, saturating angle spans; %0d mismatches", mismatch_cnt);
    if (mismatch_cnt == 0 && expected_motion.size() == 0 && !watchdog_hit) begin
      $display("quintic_time_scaling_trajectory_unit_tb: PASS");
    end else begin
      $display("quintic_time_scaling_trajectory_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/qtst_pkg.sv
rtl/qtst_pipe_div.sv
rtl/qtst_poly.sv
rtl/quintic_time_scaling_trajectory_unit.sv
tb/quintic_time_scaling_trajectory_unit_tb.sv
